FILE: hdl/catp_pkg.sv
// Shared types and constants for the cursor address template parser.
// Holds segment and format codes, template characters and the front-to-back command.
package catp_pkg;

  localparam int unsigned OffsetBitsDefault = 9;
  localparam int unsigned QueueDepth        = 2;

  localparam logic [7:0] CharPct   = 8'h25;  // '%'
  localparam logic [7:0] CharR     = 8'h72;  // 'r'
  localparam logic [7:0] CharI     = 8'h69;  // 'i'
  localparam logic [7:0] CharD     = 8'h64;  // 'd'
  localparam logic [7:0] CharTwo   = 8'h32;  // '2'
  localparam logic [7:0] CharThree = 8'h33;  // '3'
  localparam logic [7:0] CharDot   = 8'h2e;  // '.'
  localparam logic [7:0] CharPlus  = 8'h2b;  // '+'

  typedef enum logic [1:0] {
    SegBefore,
    SegBetween,
    SegAfter
  } seg_e;

  typedef enum logic [2:0] {
    FmtNone,
    FmtDecimal,
    FmtTwoDigit,
    FmtThreeDigit,
    FmtRawByte
  } fmt_e;

  // One queue entry: an optional literal, then an optional summary.
  typedef struct packed {
    logic       has_lit;
    logic       has_sum;
    logic [7:0] lit_byte;
    seg_e       lit_seg;
    seg_e       sum_seg;
    logic       column_first;
    fmt_e       row_format;
    fmt_e       column_format;
    logic       parse_error;
  } cmd_t;

endpackage

FILE: hdl/catp_front.sv
// Front end: accepts template bytes, tracks parse state and builds commands.
// Depends on catp_pkg.
module catp_front import catp_pkg::*; #(
  parameter int unsigned OffsetBits = OffsetBitsDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [7:0]            byte_value_i,
  input  logic                  end_of_template_i,
  output logic                  push_o,
  output cmd_t                  cmd_o,
  output logic [OffsetBits-1:0] row_offset_o,
  output logic [OffsetBits-1:0] column_offset_o,
  input  logic                  q_ready_i
);

  seg_e                  phase_q, phase_d;
  logic                  esc_q, esc_d;
  logic                  plus_q, plus_d;
  logic                  err_q, err_d;
  logic                  colf_q, colf_d;
  logic [OffsetBits-1:0] row_off_q, row_off_d;
  logic [OffsetBits-1:0] col_off_q, col_off_d;
  fmt_e                  row_fmt_q, row_fmt_d;
  fmt_e                  col_fmt_q, col_fmt_d;

  logic                  accept;
  logic                  have_lit;
  logic [7:0]            lit;
  logic                  end_fld;
  fmt_e                  end_fmt;
  logic                  add_row, add_col;
  logic [OffsetBits:0]   addend;
  logic [OffsetBits:0]   row_sum, col_sum;
  logic [OffsetBits-1:0] row_sat, col_sat;
  logic                  err_final;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = q_ready_i;

  // One adder per offset; carry out means saturate.
  assign row_sum = {1'b0, row_off_q} + addend;
  assign col_sum = {1'b0, col_off_q} + addend;
  assign row_sat = row_sum[OffsetBits] ? {OffsetBits{1'b1}} : row_sum[OffsetBits-1:0];
  assign col_sat = col_sum[OffsetBits] ? {OffsetBits{1'b1}} : col_sum[OffsetBits-1:0];

  always_comb begin
    phase_d   = phase_q;
    esc_d     = esc_q;
    plus_d    = plus_q;
    err_d     = err_q;
    colf_d    = colf_q;
    row_fmt_d = row_fmt_q;
    col_fmt_d = col_fmt_q;
    have_lit  = 1'b0;
    lit       = byte_value_i;
    end_fld   = 1'b0;
    end_fmt   = FmtNone;
    add_row   = 1'b0;
    add_col   = 1'b0;
    addend    = (OffsetBits+1)'(byte_value_i);

    if (!err_q && byte_value_i != 8'd0) begin
      if (plus_q) begin
        plus_d  = 1'b0;
        add_row = (phase_q == SegBefore);
        add_col = (phase_q != SegBefore);
        end_fld = 1'b1;
        end_fmt = FmtRawByte;
      end else if (esc_q) begin
        esc_d = 1'b0;
        if (byte_value_i == CharPct) begin
          have_lit = 1'b1;
        end else if (phase_q == SegAfter) begin
          err_d = 1'b1;
        end else begin
          unique case (byte_value_i)
            CharR:     colf_d = 1'b1;
            CharI: begin
              addend  = (OffsetBits+1)'(1);
              add_row = 1'b1;
              add_col = 1'b1;
            end
            CharD: begin
              end_fld = 1'b1;
              end_fmt = FmtDecimal;
            end
            CharTwo: begin
              end_fld = 1'b1;
              end_fmt = FmtTwoDigit;
            end
            CharThree: begin
              end_fld = 1'b1;
              end_fmt = FmtThreeDigit;
            end
            CharDot: begin
              end_fld = 1'b1;
              end_fmt = FmtRawByte;
            end
            CharPlus:  plus_d = 1'b1;
            default:   err_d  = 1'b1;
          endcase
        end
      end else if (byte_value_i == CharPct) begin
        esc_d = 1'b1;
      end else begin
        have_lit = 1'b1;
      end
    end

    row_off_d = add_row ? row_sat : row_off_q;
    col_off_d = add_col ? col_sat : col_off_q;

    if (end_fld) begin
      if (phase_q == SegBefore) begin
        row_fmt_d = end_fmt;
        phase_d   = SegBetween;
      end else begin
        col_fmt_d = end_fmt;
        phase_d   = SegAfter;
      end
    end

    // An escape still open at the final byte is an error.
    err_final = err_d || esc_d || plus_d;

    cmd_o.has_lit       = have_lit && !(end_of_template_i && err_final);
    cmd_o.has_sum       = end_of_template_i;
    cmd_o.lit_byte      = lit;
    cmd_o.lit_seg       = phase_q;
    cmd_o.sum_seg       = phase_d;
    cmd_o.column_first  = colf_d;
    cmd_o.row_format    = row_fmt_d;
    cmd_o.column_format = col_fmt_d;
    cmd_o.parse_error   = err_final;
    row_offset_o        = row_off_d;
    column_offset_o     = col_off_d;
    push_o              = accept && (cmd_o.has_lit || cmd_o.has_sum);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= SegBefore;
      esc_q     <= 1'b0;
      plus_q    <= 1'b0;
      err_q     <= 1'b0;
      colf_q    <= 1'b0;
      row_off_q <= '0;
      col_off_q <= '0;
      row_fmt_q <= FmtNone;
      col_fmt_q <= FmtNone;
    end else if (accept) begin
      if (end_of_template_i) begin
        // Clear per-template state after the summary.
        phase_q   <= SegBefore;
        esc_q     <= 1'b0;
        plus_q    <= 1'b0;
        err_q     <= 1'b0;
        colf_q    <= 1'b0;
        row_off_q <= '0;
        col_off_q <= '0;
        row_fmt_q <= FmtNone;
        col_fmt_q <= FmtNone;
      end else begin
        phase_q   <= phase_d;
        esc_q     <= esc_d;
        plus_q    <= plus_d;
        err_q     <= err_d;
        colf_q    <= colf_d;
        row_off_q <= row_off_d;
        col_off_q <= col_off_d;
        row_fmt_q <= row_fmt_d;
        col_fmt_q <= col_fmt_d;
      end
    end
  end

endmodule

FILE: hdl/catp_queue.sv
// Two-entry command queue between the parser front end and the result back end.
// Depends on catp_pkg for its depth.
module catp_queue import catp_pkg::*; #(
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] push_data_i,
  output logic             ready_o,
  input  logic             pop_i,
  output logic             head_valid_o,
  output logic [Width-1:0] head_data_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  logic [Width-1:0] mem_q [QueueDepth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;
  logic             do_push, do_pop;

  assign ready_o      = (count_q != CntW'(QueueDepth));
  assign head_valid_o = (count_q != '0);
  assign head_data_o  = mem_q[rd_ptr_q];
  assign do_push      = push_i && ready_o;
  assign do_pop       = pop_i && head_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

FILE: hdl/catp_back.sv
// Back end: expands each queued command into its literal and summary beats.
// Depends on catp_pkg; drives the output register of the block.
module catp_back import catp_pkg::*; #(
  parameter int unsigned OffsetBits = OffsetBitsDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  head_valid_i,
  input  cmd_t                  head_cmd_i,
  input  logic [OffsetBits-1:0] head_row_offset_i,
  input  logic [OffsetBits-1:0] head_column_offset_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  is_summary_o,
  output logic [1:0]            segment_o,
  output logic [7:0]            literal_byte_o,
  output logic                  column_first_o,
  output logic [OffsetBits-1:0] row_offset_o,
  output logic [OffsetBits-1:0] column_offset_o,
  output logic [2:0]            row_format_o,
  output logic [2:0]            column_format_o,
  output logic                  parse_error_o,
  output logic                  last_of_run_o
);

  logic                  valid_q, valid_d;
  logic                  sub_q, sub_d;   // literal of the head entry already sent
  logic                  sum_q, sum_d;
  seg_e                  seg_q, seg_d;
  logic [7:0]            lit_q, lit_d;
  logic                  colf_q, colf_d;
  logic [OffsetBits-1:0] roff_q, roff_d;
  logic [OffsetBits-1:0] coff_q, coff_d;
  fmt_e                  rfmt_q, rfmt_d;
  fmt_e                  cfmt_q, cfmt_d;
  logic                  err_q, err_d;
  logic                  last_q, last_d;
  logic                  load;

  assign load = head_valid_i && (!valid_q || out_ready_i);

  always_comb begin
    valid_d = valid_q && !out_ready_i;
    sub_d   = sub_q;
    pop_o   = 1'b0;
    sum_d   = sum_q;
    seg_d   = seg_q;
    lit_d   = lit_q;
    colf_d  = colf_q;
    roff_d  = roff_q;
    coff_d  = coff_q;
    rfmt_d  = rfmt_q;
    cfmt_d  = cfmt_q;
    err_d   = err_q;
    last_d  = last_q;
    if (load) begin
      valid_d = 1'b1;
      if (head_cmd_i.has_lit && !sub_q) begin
        sum_d  = 1'b0;
        seg_d  = head_cmd_i.lit_seg;
        lit_d  = head_cmd_i.lit_byte;
        colf_d = 1'b0;
        roff_d = '0;
        coff_d = '0;
        rfmt_d = FmtNone;
        cfmt_d = FmtNone;
        err_d  = 1'b0;
        last_d = !head_cmd_i.has_sum;
        // Hold the entry when a summary still follows.
        if (head_cmd_i.has_sum) begin
          sub_d = 1'b1;
        end else begin
          pop_o = 1'b1;
        end
      end else begin
        sum_d  = 1'b1;
        seg_d  = head_cmd_i.sum_seg;
        lit_d  = 8'd0;
        colf_d = head_cmd_i.column_first;
        roff_d = head_row_offset_i;
        coff_d = head_column_offset_i;
        rfmt_d = head_cmd_i.row_format;
        cfmt_d = head_cmd_i.column_format;
        err_d  = head_cmd_i.parse_error;
        last_d = 1'b1;
        sub_d  = 1'b0;
        pop_o  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sub_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      sub_q   <= sub_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q  <= sum_d;
    seg_q  <= seg_d;
    lit_q  <= lit_d;
    colf_q <= colf_d;
    roff_q <= roff_d;
    coff_q <= coff_d;
    rfmt_q <= rfmt_d;
    cfmt_q <= cfmt_d;
    err_q  <= err_d;
    last_q <= last_d;
  end

  assign out_valid_o     = valid_q;
  assign is_summary_o    = sum_q;
  assign segment_o       = seg_q;
  assign literal_byte_o  = lit_q;
  assign column_first_o  = colf_q;
  assign row_offset_o    = roff_q;
  assign column_offset_o = coff_q;
  assign row_format_o    = rfmt_q;
  assign column_format_o = cfmt_q;
  assign parse_error_o   = err_q;
  assign last_of_run_o   = last_q;

endmodule

FILE: hdl/cursor_address_template_parser_unit.sv
// Cursor address template parser: top level.
// Input channel: one template byte per beat (byte_value_i, end_of_template_i) on
//   in_valid_i / in_ready_o. A zero byte is skipped.
// Output channel: literal and summary beats on out_valid_o / out_ready_i. Each
//   literal byte comes out tagged with its segment; the final byte of a template
//   also gives a summary beat (flags, offsets, formats, parse_error).
//   last_of_run_o marks the final beat caused by one input byte.
// Each byte's command is registered in the queue, then in the output register.
// Throughput: one byte per cycle while the queue has room. A final byte that
//   also carries a literal gives two output beats, both sent from one queue entry.
// The front end parses and writes a command into a two-entry queue; the back
//   end expands commands into output beats. in_ready_o drops only when the
//   queue is full, so a stalled receiver backs up into the input after the
//   output register and two queued commands are occupied.
// Reset clears the parse state, the queue and the output valid; the block takes
//   input as soon as reset is released.
// After a parse error, literals already sent for that template are invalid.
// Depends on catp_pkg, catp_front, catp_queue and catp_back.
module cursor_address_template_parser_unit import catp_pkg::*; #(
  parameter int unsigned OffsetBits = OffsetBitsDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [7:0]            byte_value_i,
  input  logic                  end_of_template_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  is_summary_o,
  output logic [1:0]            segment_o,
  output logic [7:0]            literal_byte_o,
  output logic                  column_first_o,
  output logic [OffsetBits-1:0] row_offset_o,
  output logic [OffsetBits-1:0] column_offset_o,
  output logic [2:0]            row_format_o,
  output logic [2:0]            column_format_o,
  output logic                  parse_error_o,
  output logic                  last_of_run_o
);

  localparam int unsigned EntryW = $bits(cmd_t) + 2 * OffsetBits;

  logic                  push, q_ready, pop, head_valid;
  cmd_t                  push_cmd, head_cmd;
  logic [OffsetBits-1:0] push_roff, push_coff, head_roff, head_coff;
  logic [EntryW-1:0]     push_data, head_data;

  catp_front #(.OffsetBits(OffsetBits)) u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .byte_value_i,
    .end_of_template_i,
    .push_o          (push),
    .cmd_o           (push_cmd),
    .row_offset_o    (push_roff),
    .column_offset_o (push_coff),
    .q_ready_i       (q_ready)
  );

  assign push_data = {push_roff, push_coff, push_cmd};

  catp_queue #(.Width(EntryW)) u_queue (
    .clk_i,
    .rst_ni,
    .push_i       (push),
    .push_data_i  (push_data),
    .ready_o      (q_ready),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_data_o  (head_data)
  );

  assign head_cmd  = cmd_t'(head_data[$bits(cmd_t)-1:0]);
  assign head_coff = head_data[$bits(cmd_t) +: OffsetBits];
  assign head_roff = head_data[$bits(cmd_t) + OffsetBits +: OffsetBits];

  catp_back #(.OffsetBits(OffsetBits)) u_back (
    .clk_i,
    .rst_ni,
    .head_valid_i         (head_valid),
    .head_cmd_i           (head_cmd),
    .head_row_offset_i    (head_roff),
    .head_column_offset_i (head_coff),
    .pop_o                (pop),
    .out_valid_o,
    .out_ready_i,
    .is_summary_o,
    .segment_o,
    .literal_byte_o,
    .column_first_o,
    .row_offset_o,
    .column_offset_o,
    .row_format_o,
    .column_format_o,
    .parse_error_o,
    .last_of_run_o
  );

endmodule

FILE: hdl/catp_checker.sv
// Port-level checks for the cursor address template parser, bound to the top.
// Depends on catp_pkg for segment and format codes.
module catp_checker import catp_pkg::*; #(
  parameter int unsigned OffsetBits = OffsetBitsDefault
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input logic                  is_summary_o,
  input logic [1:0]            segment_o,
  input logic [7:0]            literal_byte_o,
  input logic                  column_first_o,
  input logic [OffsetBits-1:0] row_offset_o,
  input logic [OffsetBits-1:0] column_offset_o,
  input logic [2:0]            row_format_o,
  input logic [2:0]            column_format_o,
  input logic                  parse_error_o,
  input logic                  last_of_run_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(is_summary_o)
      && $stable(literal_byte_o) && $stable(last_of_run_o))
    else $error("output beat changed while stalled");

  a_sum_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_summary_o |-> last_of_run_o && literal_byte_o == 8'd0)
    else $error("summary beat not closing its run");

  a_lit_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_summary_o |-> !parse_error_o && !column_first_o
      && row_offset_o == '0 && column_offset_o == '0
      && row_format_o == FmtNone && column_format_o == FmtNone)
    else $error("literal beat carries summary fields");

  a_seg_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> segment_o == SegBefore || segment_o == SegBetween
      || segment_o == SegAfter)
    else $error("segment out of range");

  a_fmt_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_summary_o && !parse_error_o && segment_o == SegAfter
      |-> row_format_o != FmtNone && column_format_o != FmtNone)
    else $error("summary in after part without both formats");

endmodule

bind cursor_address_template_parser_unit catp_checker #(.OffsetBits(OffsetBits)) u_catp_checker (
  .clk_i,
  .rst_ni,
  .out_valid_o,
  .out_ready_i,
  .is_summary_o,
  .segment_o,
  .literal_byte_o,
  .column_first_o,
  .row_offset_o,
  .column_offset_o,
  .row_format_o,
  .column_format_o,
  .parse_error_o,
  .last_of_run_o
);
